// ===== src/fhfe_pkg.sv =====
`default_nettype none

package fhfe_pkg;

    // Default field limits, handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_SPREAD = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FIELD_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RENDER_HEAT  = 2'd2;
    localparam logic [1:0] REG_RISING_MODE  = 2'd3;

    // Register reset values.
    localparam logic [8:0] RST_FIELD_WIDTH  = 9'd256;
    localparam logic [8:0] RST_FIELD_HEIGHT = 9'd256;
    localparam logic [7:0] RST_RENDER_HEAT  = 8'd255;
    localparam logic       RST_RISING_MODE  = 1'b1;

    // Offset subtracted before the fade shift.
    localparam logic [12:0] FADE_BIAS = 13'd239;

    // Handshake flags between the spread walker and the top level.
    typedef struct packed {
        logic busy;
        logic rd_en;
        logic wr_en;
        logic done;
    } t_walk_ctrl;

    // Fade curve: min(255, max(0, 4*sum + heat - 239) >> 4).
    function automatic logic [7:0] fade(input logic [9:0] sum, input logic [7:0] heat);
        logic [12:0] v;
        logic [12:0] d;
        logic [8:0]  q;
        v = {1'b0, sum, 2'b00} + {5'd0, heat};
        d = v - FADE_BIAS;
        q = d[12:4];
        if (v < FADE_BIAS) begin
            fade = 8'd0;
        end else if (q[8]) begin
            fade = 8'hFF;
        end else begin
            fade = q[7:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/fhfe_ram.sv =====
`default_nettype none

module fhfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/fhfe_walker.sv =====
`default_nettype none

module fhfe_walker
    import fhfe_pkg::*;
#(
    parameter int XW = 8,
    parameter int YW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_src_bank,
    input  wire logic [XW-1:0]     i_wm1,
    input  wire logic [YW-1:0]     i_hm1,
    input  wire logic              i_rising,
    input  wire logic [7:0]        i_render_heat,
    input  wire logic [7:0]        i_rd_data,
    output t_walk_ctrl             o_ctrl,
    output logic [XW+YW:0]         o_rd_addr,
    output logic [XW+YW:0]         o_wr_addr,
    output logic [7:0]             o_wr_data
);

    typedef enum logic [2:0] {
        W_IDLE,
        W_RD0,
        W_RD1,
        W_RD2,
        W_RD3,
        W_WR
    } t_wstate;

    t_wstate        r_state;
    logic [XW-1:0]  r_x;
    logic [YW-1:0]  r_y;
    logic [YW-1:0]  r_row;
    logic [YW-1:0]  r_low;
    logic [9:0]     r_sum;

    logic [XW-1:0]  xl;
    logic [XW-1:0]  xr;
    logic [YW-1:0]  row_init;
    logic [YW-1:0]  low_next;
    logic           last_pixel;

    // Wrapped neighbor columns of the current pixel.
    assign xl = (r_x == '0) ? i_wm1 : r_x - XW'(1);
    assign xr = (r_x == i_wm1) ? '0 : r_x + XW'(1);

    // First upper source row: one if rising, else zero; zero on a one-row field.
    assign row_init = (i_rising && (i_hm1 != '0)) ? YW'(1) : '0;
    assign low_next = (r_low == i_hm1) ? '0 : r_low + YW'(1);

    assign last_pixel = (r_x == i_wm1) && (r_y == i_hm1);

    // Read address for each of the four taps.
    always_comb begin
        case (r_state)
            W_RD0:   o_rd_addr = {i_src_bank, r_row, xl};
            W_RD1:   o_rd_addr = {i_src_bank, r_row, r_x};
            W_RD2:   o_rd_addr = {i_src_bank, r_row, xr};
            W_RD3:   o_rd_addr = {i_src_bank, r_low, r_x};
            default: o_rd_addr = {i_src_bank, r_row, r_x};
        endcase
    end

    assign o_wr_addr = {~i_src_bank, r_y, r_x};
    assign o_wr_data = fade(r_sum + 10'(i_rd_data), i_render_heat);

    assign o_ctrl.busy  = (r_state != W_IDLE);
    assign o_ctrl.rd_en = (r_state == W_RD0) || (r_state == W_RD1) ||
                          (r_state == W_RD2) || (r_state == W_RD3);
    assign o_ctrl.wr_en = (r_state == W_WR);
    assign o_ctrl.done  = (r_state == W_WR) && last_pixel;

    // Sequencer: four reads into the shared accumulator, then one write per pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            case (r_state)
                W_IDLE: begin
                    if (i_start) begin
                        r_x     <= '0;
                        r_y     <= '0;
                        r_row   <= row_init;
                        r_low   <= (row_init == i_hm1) ? '0 : row_init + YW'(1);
                        r_state <= W_RD0;
                    end
                end
                W_RD0: begin
                    r_state <= W_RD1;
                end
                W_RD1: begin
                    r_sum   <= 10'(i_rd_data);
                    r_state <= W_RD2;
                end
                W_RD2: begin
                    r_sum   <= r_sum + 10'(i_rd_data);
                    r_state <= W_RD3;
                end
                W_RD3: begin
                    r_sum   <= r_sum + 10'(i_rd_data);
                    r_state <= W_WR;
                end
                W_WR: begin
                    if (last_pixel) begin
                        r_state <= W_IDLE;
                    end else begin
                        r_state <= W_RD0;
                        if (r_x == i_wm1) begin
                            r_x   <= '0;
                            r_y   <= r_y + YW'(1);
                            r_row <= r_low;
                            r_low <= low_next;
                        end else begin
                            r_x <= r_x + XW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/fire_heat_field_engine_core.sv =====
`default_nettype none

// Heat field engine with two banks of 8-bit pixels in one block RAM.
// Input channel (i_in_valid / o_in_stall) carries one command per transaction:
// set pixel, spread the whole field, or read pixel. A read yields one output
// transaction on o_out_valid / i_out_stall with o_heat_out; set and spread yield none.
// Registers are written over the APB port at byte addresses 0, 4, 8 and 12.
// Work per transaction:
//   set    the write lands at the acceptance edge,
//   read   one RAM read, then the output register loads once it is free,
//   spread each pixel takes four reads of the single RAM read port
//          through one accumulator, then one write; the RAM port sets the rate.
// The block takes one transaction at a time and stalls its input meanwhile.
// After reset a clearing pass zeroes all 2 * 2^clog2(MAX_WIDTH) * 2^clog2(MAX_HEIGHT)
// words of the RAM (131072 by default), one word a cycle;
// the input stays stalled until the pass ends while APB writes are still taken.
// A stalled read result holds in the output register; a following read waits
// until the register frees up.

module fire_heat_field_engine_core
    import fhfe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_pixel_x,
    input  wire logic [7:0]  i_pixel_y,
    input  wire logic [7:0]  i_pixel_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_heat_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = 1 + YW + XW;
    localparam int DEPTH = 1 << AW;
    localparam int WCW   = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
    localparam int HCW   = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
    localparam int PXW   = (XW > 8) ? XW : 8;
    localparam int PYW   = (YW > 8) ? YW : 8;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SPREAD
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    logic            r_bank;
    logic            r_rd_oor;
    logic            r_out_valid;
    logic [7:0]      r_heat;
    logic [8:0]      r_field_width;
    logic [8:0]      r_field_height;
    logic [7:0]      r_render_heat;
    logic            r_rising_mode;

    logic [XW-1:0]   wm1;
    logic [YW-1:0]   hm1;
    logic            in_acc;
    logic            in_range;
    logic            out_free;
    logic            cfg_wr;
    logic [AW-1:0]   pix_addr;

    t_walk_ctrl      walk;
    logic [AW-1:0]   walk_rd_addr;
    logic [AW-1:0]   walk_wr_addr;
    logic [7:0]      walk_wr_data;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    // Field size in use, kept as last index: zero counts as one, large values clamp.
    always_comb begin
        if (r_field_width == '0) begin
            wm1 = '0;
        end else if (WCW'(r_field_width) > WCW'(MAX_WIDTH)) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(r_field_width - 9'd1);
        end
        if (r_field_height == '0) begin
            hm1 = '0;
        end else if (HCW'(r_field_height) > HCW'(MAX_HEIGHT)) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(r_field_height - 9'd1);
        end
    end

    // Input handshake and pixel addressing in the active bank.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_range   = (PXW'(i_pixel_x) <= PXW'(wm1)) && (PYW'(i_pixel_y) <= PYW'(hm1));
    assign pix_addr   = {r_bank, YW'(i_pixel_y), XW'(i_pixel_x)};
    assign out_free   = !r_out_valid || !i_out_stall;

    // RAM port selection: clearing pass, spread walker, or single-pixel access.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = i_pixel_value;
        ram_re    = 1'b0;
        ram_raddr = pix_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = 8'd0;
            end
            S_IDLE: begin
                ram_we = in_acc && (i_command == CMD_SET) && in_range;
                ram_re = in_acc && (i_command == CMD_READ);
            end
            S_SPREAD: begin
                ram_we    = walk.wr_en;
                ram_waddr = walk_wr_addr;
                ram_wdata = walk_wr_data;
                ram_re    = walk.rd_en;
                ram_raddr = walk_rd_addr;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fhfe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fhfe_walker #(
        .XW (XW),
        .YW (YW)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_acc && (i_command == CMD_SPREAD)),
        .i_src_bank    (r_bank),
        .i_wm1         (wm1),
        .i_hm1         (hm1),
        .i_rising      (r_rising_mode),
        .i_render_heat (r_render_heat),
        .i_rd_data     (ram_rdata),
        .o_ctrl        (walk),
        .o_rd_addr     (walk_rd_addr),
        .o_wr_addr     (walk_wr_addr),
        .o_wr_data     (walk_wr_data)
    );

    // Command sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A read in progress reloads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_READ)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_command == CMD_READ)) begin
                        r_rd_oor <= !in_range;
                        r_state  <= S_READ;
                    end else if (in_acc && (i_command == CMD_SPREAD)) begin
                        r_state <= S_SPREAD;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_heat      <= r_rd_oor ? 8'd0 : ram_rdata;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SPREAD: begin
                    if (walk.done) begin
                        r_bank  <= ~r_bank;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_heat_out  = r_heat;

    // Configuration registers over APB.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= RST_FIELD_WIDTH;
            r_field_height <= RST_FIELD_HEIGHT;
            r_render_heat  <= RST_RENDER_HEAT;
            r_rising_mode  <= RST_RISING_MODE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FIELD_WIDTH:  r_field_width  <= pwdata[8:0];
                REG_FIELD_HEIGHT: r_field_height <= pwdata[8:0];
                REG_RENDER_HEAT:  r_render_heat  <= pwdata[7:0];
                REG_RISING_MODE:  r_rising_mode  <= pwdata[0];
                default:          r_rising_mode  <= r_rising_mode;
            endcase
        end
    end

    // Register read-back; the low address bits are ignored.
    always_comb begin
        case (paddr[3:2])
            REG_FIELD_WIDTH:  prdata = {23'd0, r_field_width};
            REG_FIELD_HEIGHT: prdata = {23'd0, r_field_height};
            REG_RENDER_HEAT:  prdata = {24'd0, r_render_heat};
            REG_RISING_MODE:  prdata = {31'd0, r_rising_mode};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire
